// ===== sv/fir_pkg.sv =====
// ----------------------------------------------------------------------------
// fir_pkg
// Shared types and constants of the direct-form FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  localparam int MAX_TAPS   = 64;
  localparam int TAP_IDX_W  = $clog2(MAX_TAPS);
  localparam int TAP_CNT_W  = TAP_IDX_W + 1;
  localparam int SAMPLE_W   = 16;
  localparam int FUNC_W     = 2;
  localparam int NUM_TAPS_W = 7;
  localparam int SHIFT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;
  localparam int PROD_W     = 2 * SAMPLE_W;
  localparam int ACC_W      = PROD_W + TAP_CNT_W;

  // input function codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESULT_SHIFT = 1'd1;

  localparam logic [NUM_TAPS_W-1:0] NUM_TAPS_RST     = 7'd1;
  localparam logic [SHIFT_W-1:0]    RESULT_SHIFT_RST = 5'd15;

  typedef struct packed {
    logic [FUNC_W-1:0]           func;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [SAMPLE_W-1:0]  value;
  } fir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        saturated;
  } fir_out_t;

  typedef struct packed {
    logic hist_we;
    logic hist_clr;
    logic coef_we;
    logic rd_en;
  } store_ctrl_t;

  typedef struct packed {
    logic clr;
    logic en;
  } mac_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_RUN   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ===== sv/fir_store.sv =====
// ----------------------------------------------------------------------------
// fir_store
// Sample history and coefficient memories with per-entry valid bits and
// registered read data.
// ----------------------------------------------------------------------------
module fir_store import fir_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  store_ctrl_t                 ctrl_i,
  input  logic [TAP_IDX_W-1:0]        hist_waddr_i,
  input  logic [TAP_IDX_W-1:0]        coef_waddr_i,
  input  logic signed [SAMPLE_W-1:0]  wdata_i,
  input  logic [TAP_IDX_W-1:0]        hist_raddr_i,
  input  logic [TAP_IDX_W-1:0]        coef_raddr_i,
  output logic signed [SAMPLE_W-1:0]  hist_rdata_o,
  output logic signed [SAMPLE_W-1:0]  coef_rdata_o,
  output logic                        rd_valid_o
);

  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]        hist_vld_q;
  logic [MAX_TAPS-1:0]        coef_vld_q;
  logic signed [SAMPLE_W-1:0] hist_rdata_q;
  logic signed [SAMPLE_W-1:0] coef_rdata_q;
  logic                       rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.hist_we) begin
      hist_mem[hist_waddr_i] <= wdata_i;
    end
    if (ctrl_i.coef_we) begin
      coef_mem[coef_waddr_i] <= wdata_i;
    end
  end

  // entries never written since reset (or, for the history, since a clear) read as zero
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      hist_rdata_q <= hist_vld_q[hist_raddr_i] ? hist_mem[hist_raddr_i] : '0;
      coef_rdata_q <= coef_vld_q[coef_raddr_i] ? coef_mem[coef_raddr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      coef_vld_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= ctrl_i.rd_en;
      if (ctrl_i.hist_clr) begin
        hist_vld_q <= '0;
      end else if (ctrl_i.hist_we) begin
        hist_vld_q[hist_waddr_i] <= 1'b1;
      end
      if (ctrl_i.coef_we) begin
        coef_vld_q[coef_waddr_i] <= 1'b1;
      end
    end
  end

  assign hist_rdata_o = hist_rdata_q;
  assign coef_rdata_o = coef_rdata_q;
  assign rd_valid_o   = rd_valid_q;

endmodule

// ===== sv/fir_mac.sv =====
// ----------------------------------------------------------------------------
// fir_mac
// Shared multiply-accumulate unit with output shift and saturation.
// ----------------------------------------------------------------------------
module fir_mac import fir_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mac_ctrl_t                   ctrl_i,
  input  logic signed [SAMPLE_W-1:0]  coef_i,
  input  logic signed [SAMPLE_W-1:0]  sample_i,
  input  logic [SHIFT_W-1:0]          shift_i,
  output logic                        busy_o,
  output fir_out_t                    result_o
);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_v_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W-1:0]  acc_d;
  logic signed [ACC_W-1:0]  shifted;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= coef_i * sample_i;
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = acc_q + ACC_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.en;
      acc_q    <= acc_d;
    end
  end

  assign shifted = acc_q >>> shift_i;

  always_comb begin
    result_o.saturated  = 1'b0;
    result_o.sample_out = shifted[SAMPLE_W-1:0];
    if (shifted > SAT_HI) begin
      result_o.saturated  = 1'b1;
      result_o.sample_out = SAT_HI[SAMPLE_W-1:0];
    end else if (shifted < SAT_LO) begin
      result_o.saturated  = 1'b1;
      result_o.sample_out = SAT_LO[SAMPLE_W-1:0];
    end
  end

  assign busy_o = prod_v_q;

endmodule

// ===== sv/fir_filter_direct_form.sv =====
// Push: the input transfer writes the sample; the taps are then read from the store,
// multiplied and accumulated, and the result goes to the output register (with zero
// taps, without reads). The input stalls until then, so a new push waits for the single
// shared multiply-accumulate unit and any output-side stall. Coefficient write and
// history clear finish at their input transfer. Asynchronous active-low reset empties
// history and coefficients (valid bits) and sets num_taps to 1 and result_shift to 15.
// ----------------------------------------------------------------------------
// fir_filter_direct_form
// Direct-form FIR filter, one tap per cycle through a shared MAC unit.
// ----------------------------------------------------------------------------
module fir_filter_direct_form import fir_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fir_in_t                in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output fir_out_t               out_data_o
);

  state_e                  state_q, state_d;
  logic [NUM_TAPS_W-1:0]   num_taps_q;
  logic [SHIFT_W-1:0]      result_shift_q;
  logic [TAP_IDX_W-1:0]    hist_ptr_q, hist_ptr_d;
  logic [TAP_IDX_W-1:0]    pos_q, pos_d;
  logic [TAP_CNT_W-1:0]    k_q, k_d;
  logic [TAP_CNT_W-1:0]    taps_q, taps_d;
  logic [TAP_CNT_W-1:0]    taps_clamped;
  logic                    out_valid_q, out_valid_d;
  fir_out_t                out_data_q;
  logic                    in_xfer;
  logic                    out_load;
  store_ctrl_t             st_ctrl;
  mac_ctrl_t               mac_ctrl;
  logic signed [SAMPLE_W-1:0] hist_rdata;
  logic signed [SAMPLE_W-1:0] coef_rdata;
  logic                    rd_valid;
  logic                    mac_busy;
  fir_out_t                mac_result;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign taps_clamped = (num_taps_q > TAP_CNT_W'(MAX_TAPS)) ? TAP_CNT_W'(MAX_TAPS)
                                                            : num_taps_q;

  always_comb begin
    state_d     = state_q;
    hist_ptr_d  = hist_ptr_q;
    pos_d       = pos_q;
    k_d         = k_q;
    taps_d      = taps_q;
    out_load    = 1'b0;
    st_ctrl     = '0;
    mac_ctrl    = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data_i.func == FUNC_PUSH) begin
            st_ctrl.hist_we = 1'b1;
            mac_ctrl.clr    = 1'b1;
            pos_d           = hist_ptr_q;
            hist_ptr_d      = hist_ptr_q + 1'b1;
            k_d             = '0;
            taps_d          = taps_clamped;
            state_d         = (taps_clamped == '0) ? ST_DRAIN : ST_RUN;
          end else if (in_data_i.func == FUNC_COEF) begin
            st_ctrl.coef_we = 1'b1;
          end else if (in_data_i.func == FUNC_CLEAR) begin
            st_ctrl.hist_clr = 1'b1;
            hist_ptr_d       = '0;
          end
        end
      end
      ST_RUN: begin
        // one tap read per cycle, walking the history backward
        st_ctrl.rd_en = 1'b1;
        k_d           = k_q + 1'b1;
        pos_d         = pos_q - 1'b1;
        if (k_q == taps_q - 1'b1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_valid && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    mac_ctrl.en = rd_valid;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      num_taps_q     <= NUM_TAPS_RST;
      result_shift_q <= RESULT_SHIFT_RST;
      hist_ptr_q     <= '0;
      pos_q          <= '0;
      k_q            <= '0;
      taps_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      hist_ptr_q  <= hist_ptr_d;
      pos_q       <= pos_d;
      k_q         <= k_d;
      taps_q      <= taps_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_NUM_TAPS) begin
          num_taps_q <= cfg_data_i[NUM_TAPS_W-1:0];
        end else if (cfg_idx_i == CFG_RESULT_SHIFT) begin
          result_shift_q <= cfg_data_i[SHIFT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= mac_result;
    end
  end

  fir_store u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (st_ctrl),
    .hist_waddr_i (hist_ptr_q),
    .coef_waddr_i (in_data_i.tap_index),
    .wdata_i      (in_data_i.value),
    .hist_raddr_i (pos_q),
    .coef_raddr_i (k_q[TAP_IDX_W-1:0]),
    .hist_rdata_o (hist_rdata),
    .coef_rdata_o (coef_rdata),
    .rd_valid_o   (rd_valid)
  );

  fir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef_rdata),
    .sample_i (hist_rdata),
    .shift_i  (result_shift_q),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the direct-form FIR filter. A short table of
// directed transfers and register writes runs first, followed by random
// phases with random tap counts and shifts. Every output transfer is
// compared against the table's value for some directed rows, else an
// in-bench filter model. Both handshake sides idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;
  import fir_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = MAX_TAPS + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int ITEM_TARGET  = 1900;
  localparam int QUIET_FROM   = 1650;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   reg_val;
    fir_in_t                 item;
    bit                      typed;
    fir_out_t                want;
  } dir_row_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  fir_in_t               in_data_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  fir_out_t              out_data_o;

  fir_filter_direct_form DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // filter model state
  logic signed [SAMPLE_W-1:0] hist_mem [MAX_TAPS];
  logic signed [SAMPLE_W-1:0] coef_mem [MAX_TAPS];
  logic [TAP_IDX_W-1:0]       hist_ptr;
  logic [NUM_TAPS_W-1:0]      taps_cfg;
  logic [SHIFT_W-1:0]         shift_cfg;

  fir_out_t expected_samples [$];
  int       mismatch_count = 0;
  int       cycle_count    = 0;
  int       idle_mode      = 0;
  int       stall_left     = 0;
  int       items_sent     = 0;
  dir_row_t directed_rows [$];

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fir_filter_direct_form test failed");
      $finish;
    end
  end

  // output side stall bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= (stall_left > 1);
    end else if (idle_mode != 0 &&
                 $urandom_range(0, (idle_mode == 1) ? 15 : 4) == 0) begin
      out_stall_i <= 1'b1;
      stall_left  <= $urandom_range(1, 14);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output transfer check
  always @(posedge clk_i) begin
    fir_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_samples.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected output transfer: sample_out %0d saturated %0b",
                   out_data_o.sample_out, out_data_o.saturated);
        mismatch_count++;
      end else begin
        want = expected_samples.pop_front();
        if (out_data_o.sample_out !== want.sample_out ||
            out_data_o.saturated !== want.saturated) begin
          if (mismatch_count < 10)
            $display("mismatch: sample_out exp %0d got %0d, saturated exp %0b got %0b",
                     want.sample_out, out_data_o.sample_out,
                     want.saturated, out_data_o.saturated);
          mismatch_count++;
        end
      end
    end
  end

  function automatic int active_taps();
    return (int'(taps_cfg) > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
  endfunction

  // applies one input transfer to the model, returns the filtered sample on a push
  task automatic advance_filter(input fir_in_t it, output bit has_out, output fir_out_t res);
    longint acc;
    longint shifted;
    int     pos;
    has_out = 1'b0;
    res     = '0;
    if (it.func == FUNC_COEF) begin
      coef_mem[it.tap_index] = it.value;
    end else if (it.func == FUNC_CLEAR) begin
      foreach (hist_mem[i]) hist_mem[i] = '0;
      hist_ptr = '0;
    end else if (it.func == FUNC_PUSH) begin
      hist_mem[hist_ptr] = it.value;
      pos = int'(hist_ptr);
      acc = 0;
      for (int k = 0; k < active_taps(); k++) begin
        acc = acc + longint'(coef_mem[k]) * longint'(hist_mem[pos]);
        pos = (pos == 0) ? MAX_TAPS - 1 : pos - 1;
      end
      hist_ptr = hist_ptr + 1'b1;
      shifted = acc >>> shift_cfg;
      if (shifted > 32767) begin
        res.sample_out = 16'sh7fff;
        res.saturated  = 1'b1;
      end else if (shifted < -32768) begin
        res.sample_out = 16'sh8000;
        res.saturated  = 1'b1;
      end else begin
        res.sample_out = shifted[SAMPLE_W-1:0];
        res.saturated  = 1'b0;
      end
      has_out = 1'b1;
    end
  endtask

  task automatic send_item(input fir_in_t it, input bit typed, input fir_out_t want);
    bit       has_out;
    fir_out_t pred;
    if (idle_mode != 0 && $urandom_range(0, (idle_mode == 1) ? 15 : 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    advance_filter(it, has_out, pred);
    if (has_out) expected_samples.push_back(typed ? want : pred);
    if (it.func != FUNC_UNUSED) items_sent++;
  endtask

  // registers only change once the filter has gone quiet
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    in_valid_i <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_NUM_TAPS) taps_cfg = data[NUM_TAPS_W-1:0];
    else                     shift_cfg = data[SHIFT_W-1:0];
  endtask

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int val);
    dir_row_t r;
    r         = '{kind: ROW_CFG, reg_idx: idx, reg_val: CFG_DATA_W'(val),
                  item: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [FUNC_W-1:0] f, input int idx,
                                        input int val, input bit typed,
                                        input int want_sample, input bit want_sat);
    dir_row_t r;
    r.kind           = ROW_ITEM;
    r.reg_idx        = '0;
    r.reg_val        = '0;
    r.item.func      = f;
    r.item.tap_index = TAP_IDX_W'(idx);
    r.item.value     = SAMPLE_W'(val);
    r.typed          = typed;
    r.want.sample_out = SAMPLE_W'(want_sample);
    r.want.saturated  = want_sat;
    return r;
  endfunction

  function automatic fir_in_t random_item();
    fir_in_t it;
    int      r;
    r            = $urandom_range(0, 99);
    it.tap_index = TAP_IDX_W'($urandom);
    it.value     = SAMPLE_W'($urandom);
    if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       it.value = 16'sh8000;
        1:       it.value = 16'sh7fff;
        2:       it.value = 16'sh0000;
        default: it.value = 16'shffff;
      endcase
    end
    if (r < 70) begin
      it.func = FUNC_PUSH;
    end else if (r < 85) begin
      it.func = FUNC_COEF;
      // mostly hit coefficients that are in use
      if (active_taps() > 0 && $urandom_range(0, 3) != 0)
        it.tap_index = TAP_IDX_W'($urandom_range(0, active_taps() - 1));
    end else if (r < 92) begin
      it.func = FUNC_CLEAR;
    end else begin
      it.func = FUNC_UNUSED;
    end
    return it;
  endfunction

  initial begin
    fir_out_t none;
    int       n_items;
    int       taps_val;
    int       shift_val;

    none = '0;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    foreach (coef_mem[i]) coef_mem[i] = '0;
    hist_ptr  = '0;
    taps_cfg  = NUM_TAPS_RST;
    shift_cfg = RESULT_SHIFT_RST;

    directed_rows.push_back(item_row(FUNC_PUSH, 0, 16'h1234, 1, 0, 0));
    directed_rows.push_back(item_row(FUNC_COEF, 0, -32768, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, -32768, 1, 32767, 1));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 32767, 1, -32767, 0));
    directed_rows.push_back(item_row(FUNC_COEF, 63, 32767, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_COEF, 1, 16384, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_COEF, 2, -1, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_UNUSED, 5, 32767, 0, 0, 0));
    directed_rows.push_back(cfg_row(CFG_NUM_TAPS, 64));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 100, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, -1, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, -32768, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_CLEAR, 0, 0, 0, 0, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 32767, 0, 0, 0));
    // zero taps sum nothing
    directed_rows.push_back(cfg_row(CFG_NUM_TAPS, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 5000, 1, 0, 0));
    // tap count beyond the store clamps
    directed_rows.push_back(cfg_row(CFG_NUM_TAPS, 127));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, -32768, 0, 0, 0));
    directed_rows.push_back(cfg_row(CFG_RESULT_SHIFT, 0));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 32767, 0, 0, 0));
    directed_rows.push_back(cfg_row(CFG_RESULT_SHIFT, 31));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, -32768, 0, 0, 0));
    directed_rows.push_back(cfg_row(CFG_NUM_TAPS, 1));
    directed_rows.push_back(cfg_row(CFG_RESULT_SHIFT, 15));
    directed_rows.push_back(item_row(FUNC_PUSH, 0, 7, 0, 0, 0));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG)
        write_register(directed_rows[i].reg_idx, directed_rows[i].reg_val);
      else
        send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    while (items_sent < ITEM_TARGET) begin
      // small tap counts dominate, the largest show up now and then
      case ($urandom_range(0, 19))
        0:       taps_val = 0;
        1, 2:    taps_val = MAX_TAPS;
        3:       taps_val = $urandom_range(MAX_TAPS + 1, 127);
        4, 5, 6: taps_val = $urandom_range(9, MAX_TAPS - 1);
        default: taps_val = $urandom_range(1, 8);
      endcase
      case ($urandom_range(0, 9))
        0:          shift_val = 0;
        1:          shift_val = 31;
        2, 3, 4, 5: shift_val = 15;
        default:    shift_val = $urandom_range(0, 31);
      endcase
      write_register(CFG_NUM_TAPS, CFG_DATA_W'(taps_val));
      write_register(CFG_RESULT_SHIFT, CFG_DATA_W'(shift_val));
      idle_mode = (items_sent >= QUIET_FROM) ? 0 : $urandom_range(0, 2);
      n_items = $urandom_range(40, 120);
      for (int j = 0; j < n_items && items_sent < ITEM_TARGET; j++)
        send_item(random_item(), 1'b0, none);
    end

    in_valid_i <= 1'b0;
    idle_mode = 0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("fir_filter_direct_form test passed");
    end else begin
      $display("fir_filter_direct_form test failed");
    end
    $finish;
  end

endmodule
